>>> src/hbtm_pkg.sv
package hbtm_pkg;

    localparam int NUM_SRC = 9;
    localparam int NUM_REG = 7;
    localparam int REG_BITS = 32;
    localparam int REG_IDX_BITS = 3;
    localparam int FAULT_BITS = 4;
    localparam logic [REG_BITS-1:0] TIMEOUT_RESET = 32'd1000;

    // source positions in the seen mask
    localparam int SRC_BMS1 = 0;
    localparam int SRC_BMS2 = 1;
    localparam int SRC_BMS3 = 2;
    localparam int SRC_WHL1 = 3;
    localparam int SRC_WHL2 = 4;
    localparam int SRC_THR  = 5;
    localparam int SRC_MOT  = 6;
    localparam int SRC_UI   = 7;
    localparam int SRC_PWR  = 8;

    // configuration register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_BMS  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_WHL1 = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_WHL2 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_THR  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_MOT  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_UI   = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_PWR  = 3'd6;

    // timeout register that guards each source
    localparam logic [REG_IDX_BITS-1:0] SRC_REG [NUM_SRC] = '{
        REG_BMS, REG_BMS, REG_BMS, REG_WHL1, REG_WHL2,
        REG_THR, REG_MOT, REG_UI, REG_PWR
    };

    // fault codes
    localparam logic [FAULT_BITS-1:0] FAULT_OK        = 4'd0;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_BMS    = 4'd1;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_WHL1   = 4'd2;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_WHL2   = 4'd3;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_THR    = 4'd4;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_MOT    = 4'd5;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_UI     = 4'd6;
    localparam logic [FAULT_BITS-1:0] FAULT_NS_PWR    = 4'd7;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_BMS  = 4'd8;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_WHL1 = 4'd9;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_WHL2 = 4'd10;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_MOT  = 4'd11;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_UI   = 4'd12;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_THR  = 4'd13;
    localparam logic [FAULT_BITS-1:0] FAULT_LOST_PWR  = 4'd14;

    typedef logic [NUM_REG-1:0][REG_BITS-1:0] timeout_arr_t;

    typedef struct packed {
        logic [NUM_SRC-1:0] started;
        logic [NUM_SRC-1:0] lost;
    } src_status_t;

endpackage

>>> src/hbtm_cfg_regs.sv
module hbtm_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hbtm_pkg::REG_IDX_BITS-1:0]     cfg_index,
    input  logic [hbtm_pkg::REG_BITS-1:0]         cfg_data,
    output hbtm_pkg::timeout_arr_t                timeouts
);

    hbtm_pkg::timeout_arr_t timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hbtm_pkg::NUM_REG; i++)
            begin
                timeout_reg[i] <= hbtm_pkg::TIMEOUT_RESET;
            end
        end
        else if (cfg_we)
        begin
            // an index past the last register is dropped
            for (int i = 0; i < hbtm_pkg::NUM_REG; i++)
            begin
                if (cfg_index == hbtm_pkg::REG_IDX_BITS'(i))
                begin
                    timeout_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign timeouts = timeout_reg;

endmodule

>>> src/hbtm_tracker.sv
module hbtm_tracker
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              upd,
    input  logic [hbtm_pkg::NUM_SRC-1:0]      mask,
    input  logic [TIME_BITS-1:0]              now,
    input  hbtm_pkg::timeout_arr_t            timeouts,
    output hbtm_pkg::src_status_t             status
);

    localparam int CMP_BITS = (TIME_BITS > hbtm_pkg::REG_BITS) ? TIME_BITS
                                                               : hbtm_pkg::REG_BITS;

    logic [hbtm_pkg::NUM_SRC-1:0] started_reg;
    logic [hbtm_pkg::NUM_SRC-1:0] started_next;
    logic [TIME_BITS-1:0]         last_reg  [hbtm_pkg::NUM_SRC];
    logic [TIME_BITS-1:0]         elapsed   [hbtm_pkg::NUM_SRC];
    logic [hbtm_pkg::NUM_SRC-1:0] lost;

    always_comb
    begin
        started_next = started_reg | mask;
        for (int i = 0; i < hbtm_pkg::NUM_SRC; i++)
        begin
            elapsed[i] = now - last_reg[i];
            // a source seen in this tick is never reported as lost
            lost[i] = !mask[i] &&
                      (CMP_BITS'(elapsed[i]) >
                       CMP_BITS'(timeouts[hbtm_pkg::SRC_REG[i]]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= '0;
            for (int i = 0; i < hbtm_pkg::NUM_SRC; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            started_reg <= started_next;
            for (int i = 0; i < hbtm_pkg::NUM_SRC; i++)
            begin
                if (mask[i])
                begin
                    last_reg[i] <= now;
                end
            end
        end
    end

    assign status.started = started_next;
    assign status.lost    = lost;

endmodule

>>> src/hbtm_fault_enc.sv
module hbtm_fault_enc
(
    input  hbtm_pkg::src_status_t                 status,
    output logic [hbtm_pkg::FAULT_BITS-1:0]       code
);

    logic [hbtm_pkg::NUM_SRC-1:0] st;
    logic [hbtm_pkg::NUM_SRC-1:0] ls;

    assign st = status.started;
    assign ls = status.lost;

    // never-started checks win over lost checks; the lost order differs
    always_comb
    begin
        if (!(st[hbtm_pkg::SRC_BMS1] && st[hbtm_pkg::SRC_BMS2] && st[hbtm_pkg::SRC_BMS3]))
            code = hbtm_pkg::FAULT_NS_BMS;
        else if (!st[hbtm_pkg::SRC_WHL1])
            code = hbtm_pkg::FAULT_NS_WHL1;
        else if (!st[hbtm_pkg::SRC_WHL2])
            code = hbtm_pkg::FAULT_NS_WHL2;
        else if (!st[hbtm_pkg::SRC_THR])
            code = hbtm_pkg::FAULT_NS_THR;
        else if (!st[hbtm_pkg::SRC_MOT])
            code = hbtm_pkg::FAULT_NS_MOT;
        else if (!st[hbtm_pkg::SRC_UI])
            code = hbtm_pkg::FAULT_NS_UI;
        else if (!st[hbtm_pkg::SRC_PWR])
            code = hbtm_pkg::FAULT_NS_PWR;
        else if (ls[hbtm_pkg::SRC_BMS1] || ls[hbtm_pkg::SRC_BMS2] || ls[hbtm_pkg::SRC_BMS3])
            code = hbtm_pkg::FAULT_LOST_BMS;
        else if (ls[hbtm_pkg::SRC_WHL1])
            code = hbtm_pkg::FAULT_LOST_WHL1;
        else if (ls[hbtm_pkg::SRC_WHL2])
            code = hbtm_pkg::FAULT_LOST_WHL2;
        else if (ls[hbtm_pkg::SRC_MOT])
            code = hbtm_pkg::FAULT_LOST_MOT;
        else if (ls[hbtm_pkg::SRC_UI])
            code = hbtm_pkg::FAULT_LOST_UI;
        else if (ls[hbtm_pkg::SRC_THR])
            code = hbtm_pkg::FAULT_LOST_THR;
        else if (ls[hbtm_pkg::SRC_PWR])
            code = hbtm_pkg::FAULT_LOST_PWR;
        else
            code = hbtm_pkg::FAULT_OK;
    end

endmodule

>>> src/heartbeat_timeout_monitor.sv
// channel   handshake                 payload
// input     in_valid / in_stall       seen_mask[8:0], now_ms[31:0]
// output    out_valid / out_stall     fault_code[3:0]
// config    cfg_we (no handshake)     cfg_index[2:0], cfg_data[31:0]
//
// one item per cycle sustained while out_stall is low; out_valid rises when the accepted item moves
// from the input register through tracker update, compare and priority encode into the result register
// reset clears flags, last-seen times and valid bits, timeouts return to 1000
// out_stall holds the result register and the input register backs up behind it;
// in_stall follows out_stall combinationally only when both stages are full
module heartbeat_timeout_monitor
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [hbtm_pkg::NUM_SRC-1:0]          seen_mask,
    input  logic [31:0]                           now_ms,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [hbtm_pkg::FAULT_BITS-1:0]       fault_code,
    input  logic                                  cfg_we,
    input  logic [hbtm_pkg::REG_IDX_BITS-1:0]     cfg_index,
    input  logic [hbtm_pkg::REG_BITS-1:0]         cfg_data
);

    logic                                 s1_valid_reg;
    logic [hbtm_pkg::NUM_SRC-1:0]         s1_mask_reg;
    logic [31:0]                          s1_now_reg;
    logic                                 out_valid_reg;
    logic [hbtm_pkg::FAULT_BITS-1:0]      fault_code_reg;
    logic [hbtm_pkg::FAULT_BITS-1:0]      fault_code_next;
    logic                                 s2_load;
    logic                                 s1_load;
    logic [TIME_BITS-1:0]                 now_cut;
    hbtm_pkg::timeout_arr_t               timeouts;
    hbtm_pkg::src_status_t                status;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s2_load;
    assign now_cut  = TIME_BITS'(s1_now_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load || s2_load)
            begin
                s1_valid_reg <= s1_load;
            end
            if (s2_load || !out_stall)
            begin
                out_valid_reg <= s2_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_mask_reg <= seen_mask;
            s1_now_reg  <= now_ms;
        end
        if (s2_load)
        begin
            fault_code_reg <= fault_code_next;
        end
    end

    hbtm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timeouts  (timeouts)
    );

    hbtm_tracker #(.TIME_BITS(TIME_BITS)) u_tracker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (s2_load),
        .mask     (s1_mask_reg),
        .now      (now_cut),
        .timeouts (timeouts),
        .status   (status)
    );

    hbtm_fault_enc u_enc
    (
        .status (status),
        .code   (fault_code_next)
    );

    assign out_valid  = out_valid_reg;
    assign fault_code = fault_code_reg;

`ifndef SYNTH
    // a result only appears after an item sat in the input register
    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result without a pending item");

    // a moved item shows up as a result next cycle
    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> out_valid)
        else $error("loaded item did not produce a result");

    // only defined codes leave the block
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fault_code <= hbtm_pkg::FAULT_LOST_PWR))
        else $error("fault code out of range");
`endif

endmodule

>>> tb/hbtm_fault_checker.sv
module hbtm_fault_checker
    import hbtm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [NUM_SRC-1:0]      seen_mask,
    input  logic [31:0]             now_ms,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [FAULT_BITS-1:0]   fault_code,
    input  logic                    cfg_we,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data,
    output int                      mismatches,
    output int                      faults_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [NUM_SRC-1:0]  started;
    logic [31:0]         last_seen_ms [NUM_SRC];
    timeout_arr_t        timeout_ms;
    logic [FAULT_BITS-1:0] expected_faults [$];

    function automatic logic [FAULT_BITS-1:0] predict_fault(input logic [NUM_SRC-1:0] mask,
                                                            input logic [31:0] now);
        logic [NUM_SRC-1:0]    lost;
        logic [31:0]           elapsed;
        logic [FAULT_BITS-1:0] code;
        for (int s = 0; s < NUM_SRC; s++)
        begin
            if (mask[s])
            begin
                started[s] = 1'b1;
                last_seen_ms[s] = now;
            end
        end
        // liveness is judged on the updated state, elapsed wraps modulo 2^32
        for (int s = 0; s < NUM_SRC; s++)
        begin
            elapsed = now - last_seen_ms[s];
            lost[s] = elapsed > timeout_ms[SRC_REG[s]];
        end
        if (!(&started[SRC_BMS3:SRC_BMS1]))
            code = FAULT_NS_BMS;
        else if (!started[SRC_WHL1])
            code = FAULT_NS_WHL1;
        else if (!started[SRC_WHL2])
            code = FAULT_NS_WHL2;
        else if (!started[SRC_THR])
            code = FAULT_NS_THR;
        else if (!started[SRC_MOT])
            code = FAULT_NS_MOT;
        else if (!started[SRC_UI])
            code = FAULT_NS_UI;
        else if (!started[SRC_PWR])
            code = FAULT_NS_PWR;
        // the loss list ranks motor and user interface ahead of throttle
        else if (|lost[SRC_BMS3:SRC_BMS1])
            code = FAULT_LOST_BMS;
        else if (lost[SRC_WHL1])
            code = FAULT_LOST_WHL1;
        else if (lost[SRC_WHL2])
            code = FAULT_LOST_WHL2;
        else if (lost[SRC_MOT])
            code = FAULT_LOST_MOT;
        else if (lost[SRC_UI])
            code = FAULT_LOST_UI;
        else if (lost[SRC_THR])
            code = FAULT_LOST_THR;
        else if (lost[SRC_PWR])
            code = FAULT_LOST_PWR;
        else
            code = FAULT_OK;
        return code;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [FAULT_BITS-1:0] want;
        if (!rst_n)
        begin
            started = '0;
            for (int s = 0; s < NUM_SRC; s++)
                last_seen_ms[s] = '0;
            for (int r = 0; r < NUM_REG; r++)
                timeout_ms[r] = TIMEOUT_RESET;
            expected_faults.delete();
            mismatches = 0;
        end
        else
        begin
            // writes to an index past the last register are dropped
            if (cfg_we && cfg_index < NUM_REG)
                timeout_ms[cfg_index] = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_faults.size() == 0)
                begin
                    $display("%0t: fault_code expected none, actual %0d", $time, fault_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_faults.pop_front();
                    if (fault_code !== want)
                    begin
                        $display("%0t: fault_code expected %0d, actual %0d",
                                 $time, want, fault_code);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_faults.push_back(predict_fault(seen_mask, now_ms));
        end
        faults_pending = expected_faults.size();
    end

endmodule

>>> tb/tb_heartbeat_timeout_monitor.sv
module tb_heartbeat_timeout_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import hbtm_pkg::*;

    localparam int DIRECTED_ITEMS = 25;
    localparam int ITEMS_PER_PLAN = 150;
    localparam int DRAIN_CYCLES   = 6;
    localparam logic [REG_IDX_BITS-1:0] REG_NONE = 3'd7;

    // directed walk: start-up order, loss order, strict compare, time wrap
    localparam logic [NUM_SRC-1:0] DIR_MASK [DIRECTED_ITEMS] = '{
        9'h000, 9'h001, 9'h006, 9'h008, 9'h010, 9'h020, 9'h040, 9'h080, 9'h100,
        9'h1FF, 9'h000, 9'h000,
        9'h007, 9'h00F, 9'h01F, 9'h05F, 9'h0DF, 9'h0FF, 9'h1FF,
        9'h1FF, 9'h000, 9'h000, 9'h1FF, 9'h000, 9'h000
    };
    localparam logic [31:0] DIR_TIME [DIRECTED_ITEMS] = '{
        32'd0, 32'd5, 32'd10, 32'd20, 32'd30, 32'd40, 32'd50, 32'd60, 32'd70,
        32'd100, 32'd1100, 32'd1101,
        32'd2200, 32'd2200, 32'd2200, 32'd2200, 32'd2200, 32'd2200, 32'd2200,
        32'hFFFF_FF00, 32'h0000_0010, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_03E7, 32'h0000_03E8
    };

    typedef enum {TO_RESET, TO_ZERO, TO_MAX, TO_SMALL, TO_FULL, TO_MIXED} timeout_plan_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [NUM_SRC-1:0]      seen_mask = '0;
    logic [31:0]             now_ms = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [FAULT_BITS-1:0]   fault_code;
    logic                    cfg_we = 1'b0;
    logic [REG_IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]     cfg_data = '0;
    int                      mismatches;
    int                      faults_pending;

    int sent_items = 0;
    int taken_results = 0;
    bit send_fast;
    bit take_fast;

    heartbeat_timeout_monitor DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .seen_mask  (seen_mask),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .fault_code (fault_code),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hbtm_fault_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .seen_mask      (seen_mask),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fault_code     (fault_code),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .faults_pending (faults_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input logic [NUM_SRC-1:0] mask, input logic [31:0] t);
        int gap;
        if (sent_items % 32 == 0)
            send_fast = ($urandom_range(0, 3) == 0);
        sent_items++;
        gap = send_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        seen_mask <= mask;
        now_ms <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // leaves cfg_we high, the caller drops it after the last write
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (faults_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        timeout_plan_t      plan;
        int unsigned        step_max;
        int                 seen_pct;
        logic [31:0]        clock_ms;
        logic [31:0]        t;
        logic [NUM_SRC-1:0] mask;
        logic [REG_BITS-1:0] value;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ITEMS; i++)
            send_item(DIR_MASK[i], DIR_TIME[i]);
        clock_ms = DIR_TIME[DIRECTED_ITEMS-1];

        for (int p = 0; p < plan.num(); p++)
        begin
            plan = timeout_plan_t'(p);
            drain();
            for (int r = REG_BMS; r <= REG_PWR; r++)
            begin
                case (plan)
                    TO_RESET: value = TIMEOUT_RESET;
                    TO_ZERO:  value = '0;
                    TO_MAX:   value = '1;
                    TO_SMALL: value = $urandom_range(0, 100);
                    TO_FULL:  value = $urandom;
                    default:
                    begin
                        case ($urandom_range(0, 2))
                            0:       value = '0;
                            1:       value = '1;
                            default: value = $urandom_range(0, 500);
                        endcase
                    end
                endcase
                write_reg(r[REG_IDX_BITS-1:0], value);
            end
            write_reg(REG_NONE, $urandom);
            cfg_we <= 1'b0;

            case (plan)
                TO_RESET:
                begin
                    step_max = 400;
                    seen_pct = 70;
                end
                TO_ZERO:
                begin
                    step_max = 2;
                    seen_pct = 90;
                end
                TO_MAX:
                begin
                    step_max = 32'hFFFF_FFFF;
                    seen_pct = 50;
                end
                TO_SMALL:
                begin
                    step_max = 40;
                    seen_pct = 70;
                end
                TO_FULL:
                begin
                    step_max = 32'hFFFF_FFFF;
                    seen_pct = 50;
                end
                default:
                begin
                    step_max = 200;
                    seen_pct = 75;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PLAN; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // noise: any mask at any time
                    mask = NUM_SRC'($urandom_range(0, 511));
                    t = $urandom;
                end
                else
                begin
                    if ($urandom_range(0, 99) < 3)
                        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                    else
                        clock_ms = clock_ms + $urandom_range(0, step_max);
                    for (int s = 0; s < NUM_SRC; s++)
                        mask[s] = ($urandom_range(0, 99) < seen_pct);
                    t = clock_ms;
                end
                send_item(mask, t);
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb_heartbeat_timeout_monitor passed");
        else
            $display("tb_heartbeat_timeout_monitor failed");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken_results % 32 == 0)
                take_fast = ($urandom_range(0, 3) == 0);
            stall = take_fast ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            taken_results++;
            @(negedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_heartbeat_timeout_monitor failed");
        $finish;
    end

endmodule
